>>> sv/single_star_wildcard_match_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the single-star wildcard matcher
// Implication checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SINGLE_STAR_WILDCARD_MATCH_TOP_ASSERT_SVH
`define SINGLE_STAR_WILDCARD_MATCH_TOP_ASSERT_SVH

// same-cycle implication
`define SSW_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssw: same-cycle check failed");

// next-cycle implication
`define SSW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssw: next-cycle check failed");

`endif

>>> sv/ssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared types, constants and helpers of the single-star wildcard matcher.
// ----------------------------------------------------------------------------
package ssw_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int BYTE_W        = 8;
   localparam int PAT_W         = PATTERN_BYTES * BYTE_W;
   localparam int PAT_IDX_W     = $clog2(PATTERN_BYTES);
   localparam int LEN_W         = 5;
   localparam int CFG_W         = 64;
   localparam int CSR_IDX_W     = 2;

   localparam logic [BYTE_W-1:0] STAR      = 8'h2A;
   localparam logic [LEN_W-1:0]  COUNT_MAX = 5'd31;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

   typedef enum logic [2:0] {
      KIND_EMPTY,
      KIND_ANY,
      KIND_SUFFIX,
      KIND_PREFIX,
      KIND_AROUND,
      KIND_SPLIT,
      KIND_EXACT
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [LEN_W-1:0]  len;
      logic [LEN_W-1:0]  plen;
      logic [LEN_W-1:0]  slen;
      logic [LEN_W-1:0]  mlen;
   } shape_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] p,
                                                  input logic [PAT_IDX_W-1:0] i);
      return p[{i, 3'b000} +: BYTE_W];
   endfunction

   function automatic logic [PATTERN_BYTES-1:0] low_mask(input logic [LEN_W-1:0] n);
      logic [PATTERN_BYTES-1:0] m;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         m[j] = (LEN_W'(j) < n);
      end
      return m;
   endfunction

endpackage

>>> sv/ssw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_cell
// One window byte: hold, take or clear the neighbor's byte, compare against two
// aligned pattern bytes.
// ----------------------------------------------------------------------------
module ssw_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  ssw_pkg::cell_ctl_type      ctl,
   input  logic [ssw_pkg::BYTE_W-1:0] byte_in,
   input  logic [ssw_pkg::BYTE_W-1:0] ref_end,
   input  logic [ssw_pkg::BYTE_W-1:0] ref_mid,
   output logic [ssw_pkg::BYTE_W-1:0] byte_out,
   output logic                       eq_end,
   output logic                       eq_mid
);
   import ssw_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in_c;
   logic [BYTE_W-1:0] win;

   assign win       = ctl.shift ? byte_in : byte_ff;
   assign byte_in_c = ctl.clear ? '0 : win;
   assign eq_end    = (win == ref_end);
   assign eq_mid    = (win == ref_mid);
   assign byte_out  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in_c;
      end
   end

endmodule

>>> sv/ssw_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_shape
// Derive the pattern kind and the prefix, suffix and middle lengths.
// ----------------------------------------------------------------------------
module ssw_shape (
   input  logic [ssw_pkg::PAT_W-1:0] pattern,
   input  logic [ssw_pkg::LEN_W-1:0] length,
   output ssw_pkg::shape_type        shape
);
   import ssw_pkg::*;

   logic [LEN_W-1:0]     len_c;
   logic                 front;
   logic                 back;
   logic                 found;
   logic [PAT_IDX_W-1:0] first;

   always_comb begin
      len_c = (length > LEN_W'(PATTERN_BYTES)) ? LEN_W'(PATTERN_BYTES) : length;
      front = (pat_byte(pattern, '0) == STAR);
      back  = (len_c != '0) &&
              (pat_byte(pattern, PAT_IDX_W'(len_c - 5'd1)) == STAR);
      found = 1'b0;
      first = '0;
      for (int j = PATTERN_BYTES - 1; j >= 0; j--) begin
         if ((LEN_W'(j) < len_c) && (pat_byte(pattern, PAT_IDX_W'(j)) == STAR)) begin
            found = 1'b1;
            first = PAT_IDX_W'(j);
         end
      end

      shape.kind = KIND_EXACT;
      shape.len  = len_c;
      shape.plen = '0;
      shape.slen = '0;
      shape.mlen = '0;
      if (len_c == '0) begin
         shape.kind = KIND_EMPTY;
      end else if ((len_c == 5'd1) && front) begin
         shape.kind = KIND_ANY;
      end else if (front && back) begin
         shape.kind = KIND_AROUND;
         shape.mlen = len_c - 5'd2;
      end else if (front) begin
         shape.kind = KIND_SUFFIX;
         shape.slen = len_c - 5'd1;
      end else if (back) begin
         shape.kind = KIND_PREFIX;
         shape.plen = len_c - 5'd1;
      end else if (found) begin
         shape.kind = KIND_SPLIT;
         shape.plen = {1'b0, first};
         shape.slen = len_c - {1'b0, first} - 5'd1;
      end
   end

endmodule

>>> sv/single_star_wildcard_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_star_wildcard_match_top
// Stream subject bytes through a row of window cells and flag a match of
// the configured single-star pattern on the closing word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_character, req_no_char, req_last
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_matched
//  csr     | in        | csr_write            | csr_index, csr_data
//
//  The match of a closing word is computed in the cycle it is taken and is
//  registered into the result buffer before it shows on rsp.
//  A two-entry result buffer (output register plus skid) lets req keep flowing
//  while a result waits; req_ready drops only when both entries are full.
//  Synchronous reset clears the window, counter, piece flag and result buffer.
// ----------------------------------------------------------------------------
`include "single_star_wildcard_match_top_assert.svh"

module single_star_wildcard_match_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ssw_pkg::BYTE_W-1:0]    req_character,
   input  logic                          req_no_char,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_matched,
   input  logic                          csr_write,
   input  logic [ssw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ssw_pkg::CFG_W-1:0]     csr_data
);
   import ssw_pkg::*;

   logic [CFG_W-1:0]  pat_lo_ff;
   logic [CFG_W-1:0]  pat_hi_ff;
   logic [LEN_W-1:0]  pat_len_ff;
   logic [PAT_W-1:0]  pattern;
   shape_type         shape;

   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              prefix_ff, prefix_in;
   logic              piece_ff, piece_in;
   logic [LEN_W-1:0]  cnt_new;
   logic              prefix_new;
   logic              piece_new;

   logic              head_valid_ff, head_valid_in;
   logic              head_ff, head_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              skid_ff, skid_in;

   logic              accept;
   logic              push;
   logic              pop;
   logic              match;

   cell_ctl_type              cell_ctl;
   logic [BYTE_W-1:0]         end_pat [PATTERN_BYTES+1];
   logic [BYTE_W-1:0]         link    [PATTERN_BYTES+1];
   logic [PATTERN_BYTES-1:0]  eq_end;
   logic [PATTERN_BYTES-1:0]  eq_mid;

   assign pattern     = {pat_hi_ff, pat_lo_ff};
   assign req_ready   = !skid_valid_ff;
   assign accept      = req_valid && req_ready;
   assign push        = accept && req_last;
   assign pop         = head_valid_ff && rsp_ready;
   assign rsp_valid   = head_valid_ff;
   assign rsp_matched = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff  <= '0;
         pat_hi_ff  <= '0;
         pat_len_ff <= 5'd1;
      end else if (csr_write) begin
         case (csr_index)
            REG_PATTERN_LOW:    pat_lo_ff  <= csr_data;
            REG_PATTERN_HIGH:   pat_hi_ff  <= csr_data;
            REG_PATTERN_LENGTH: pat_len_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   ssw_shape u_shape (
      .pattern (pattern),
      .length  (pat_len_ff),
      .shape   (shape)
   );

   // align pattern so that entry j is the byte that window byte j must equal
   always_comb begin
      logic [LEN_W:0] pos;
      for (int j = 0; j <= PATTERN_BYTES; j++) begin
         pos = {1'b0, shape.len} - (LEN_W+1)'(j + 1);
         end_pat[j] = pos[LEN_W] ? '0 : pat_byte(pattern, pos[PAT_IDX_W-1:0]);
      end
   end

   assign cell_ctl.shift = accept && !req_no_char;
   assign cell_ctl.clear = push;
   assign link[0]        = req_character;

   genvar g;
   generate
      for (g = 0; g < PATTERN_BYTES; g++) begin : g_cell
         ssw_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (cell_ctl),
            .byte_in  (link[g]),
            .ref_end  (end_pat[g]),
            .ref_mid  (end_pat[g+1]),
            .byte_out (link[g+1]),
            .eq_end   (eq_end[g]),
            .eq_mid   (eq_mid[g])
         );
      end
   endgenerate

   always_comb begin
      logic tail_suffix;
      logic tail_split;
      logic tail_exact;
      logic tail_mid;

      cnt_new    = cnt_ff;
      prefix_new = prefix_ff;
      if (!req_no_char) begin
         if ((cnt_ff < shape.plen) &&
             (req_character != pat_byte(pattern, cnt_ff[PAT_IDX_W-1:0]))) begin
            prefix_new = 1'b0;
         end
         if (cnt_ff != COUNT_MAX) begin
            cnt_new = cnt_ff + 5'd1;
         end
      end

      tail_suffix = (cnt_new >= shape.slen) && (&(eq_end | ~low_mask(shape.slen)));
      tail_split  = tail_suffix;
      tail_exact  = (cnt_new >= shape.len)  && (&(eq_end | ~low_mask(shape.len)));
      tail_mid    = (cnt_new >= shape.mlen) && (&(eq_mid | ~low_mask(shape.mlen)));

      piece_new = piece_ff ||
                  (!req_no_char && (shape.kind == KIND_AROUND) && tail_mid);

      case (shape.kind)
         KIND_EMPTY:  match = (cnt_new == '0);
         KIND_ANY:    match = 1'b1;
         KIND_SUFFIX: match = tail_suffix;
         KIND_PREFIX: match = (cnt_new >= shape.plen) && prefix_new;
         KIND_AROUND: match = (shape.mlen == '0) || piece_new;
         KIND_SPLIT:  match = (cnt_new >= (shape.plen + shape.slen)) && prefix_new &&
                              tail_split;
         default:     match = (cnt_new == shape.len) && tail_exact;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      prefix_in = prefix_ff;
      piece_in  = piece_ff;
      if (push) begin
         cnt_in    = '0;
         prefix_in = 1'b1;
         piece_in  = 1'b0;
      end else if (accept) begin
         cnt_in    = cnt_new;
         prefix_in = prefix_new;
         piece_in  = piece_new;
      end
   end

   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         head_valid_in = skid_valid_ff;
         head_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (push) begin
         if (!head_valid_in) begin
            head_valid_in = 1'b1;
            head_in       = match;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         prefix_ff     <= 1'b1;
         piece_ff      <= 1'b0;
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         prefix_ff     <= prefix_in;
         piece_ff      <= piece_in;
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   `SSW_ASSERT_NOW(a_skid_behind_head, skid_valid_ff, head_valid_ff)
   `SSW_ASSERT_NEXT(a_push_lands, push && !head_valid_ff, head_valid_ff)
   `SSW_ASSERT_NEXT(a_string_cleared, push, (cnt_ff == '0) && prefix_ff && !piece_ff)
   `SSW_ASSERT_NEXT(a_empty_word_holds, accept && req_no_char && !req_last,
                    cnt_ff == $past(cnt_ff))

endmodule
